>>> rtl/rdq_pkg.sv
// Package for the ring deque: command and status codes, result record, FSM states.
`timescale 1ns / 1ps

package rdq_pkg;

  localparam int unsigned DATA_W = 32;

  // Request command codes (codes 5 to 7 are unused and ignored)
  typedef enum logic [2:0] {
    CMD_INS_HEAD = 3'd0,
    CMD_INS_TAIL = 3'd1,
    CMD_DEL_HEAD = 3'd2,
    CMD_DEL_TAIL = 3'd3,
    CMD_DUMP     = 3'd4
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  // Control states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

  // One result record
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_e                  status;
    logic                     last;
  } res_t;

endpackage

>>> rtl/rdq_out_stage.sv
// Output register stage: holds one result until the consumer takes it.
`timescale 1ns / 1ps

module rdq_out_stage (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  rdq_pkg::res_t res_i,
  input  logic        stall_i,
  output logic        valid_o,
  output logic        free_o,
  output rdq_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  rdq_pkg::res_t res_q;

  // Slot can take a new result when empty or being drained this cycle
  assign free_o = !valid_q || !stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> rtl/ring_deque_with_dump_top.sv
// Ring deque top level: entry store, head/count pointers, control FSM.
// Latency: an insert or delete result is registered and valid the cycle after accept.
// Throughput: inserts and deletes take one request per cycle while the output drains.
// Dump results pass the registered store read, then the output stage, one per cycle
// unless stalled (one store read port); requests stall until the last dump result loads.
// Reset clears head, count, FSM and output valid; the entry store is not cleared.
`timescale 1ns / 1ps

module ring_deque_with_dump_top #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         command_i,
  input  logic signed [31:0] value_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] value_out_o,
  output logic [1:0]         status_o,
  output logic               last_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [PtrW-1:0] ring_pos(input logic [PtrW-1:0] base,
                                              input logic [PtrW-1:0] off);
    logic [PtrW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PtrW+1)'(DEPTH)) begin
      sum = sum - (PtrW+1)'(DEPTH);
    end
    return sum[PtrW-1:0];
  endfunction

  rdq_pkg::state_e state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PtrW-1:0] off_q, off_d;

  logic                       wr_en, rd_en;
  logic [PtrW-1:0]            waddr, raddr;
  logic [rdq_pkg::DATA_W-1:0] rd_data_q;
  logic [rdq_pkg::DATA_W-1:0] entry_store_q [DEPTH];

  logic          accept, load, out_free, full, empty, dump_last;
  rdq_pkg::res_t res, res_out;

  assign in_stall_o = (state_q != rdq_pkg::ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign dump_last  = ((CntW'(off_q) + CntW'(1)) == count_q);

  // Next state, pointer update, store access and result build
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    off_d      = off_q;
    wr_en      = 1'b0;
    waddr      = head_q;
    rd_en      = 1'b0;
    raddr      = head_q;
    load       = 1'b0;
    res.value  = '0;
    res.status = rdq_pkg::STS_OK;
    res.last   = 1'b1;
    case (state_q)
      rdq_pkg::ST_IDLE: begin
        if (accept) begin
          case (rdq_pkg::cmd_e'(command_i))
            rdq_pkg::CMD_INS_HEAD: begin
              load = 1'b1;
              if (full) begin
                res.status = rdq_pkg::STS_FULL;
              end else begin
                head_d  = (head_q == '0) ? PtrW'(DEPTH - 1) : head_q - PtrW'(1);
                wr_en   = 1'b1;
                waddr   = head_d;
                count_d = count_q + CntW'(1);
              end
            end
            rdq_pkg::CMD_INS_TAIL: begin
              load = 1'b1;
              if (full) begin
                res.status = rdq_pkg::STS_FULL;
              end else begin
                wr_en   = 1'b1;
                waddr   = ring_pos(head_q, count_q[PtrW-1:0]);
                count_d = count_q + CntW'(1);
              end
            end
            rdq_pkg::CMD_DEL_HEAD: begin
              load = 1'b1;
              if (empty) begin
                res.status = rdq_pkg::STS_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
                head_d  = (count_d == '0) ? '0 : ring_pos(head_q, PtrW'(1));
              end
            end
            rdq_pkg::CMD_DEL_TAIL: begin
              load = 1'b1;
              if (empty) begin
                res.status = rdq_pkg::STS_EMPTY;
              end else begin
                count_d = count_q - CntW'(1);
                if (count_d == '0) begin
                  head_d = '0;
                end
              end
            end
            rdq_pkg::CMD_DUMP: begin
              if (empty) begin
                load       = 1'b1;
                res.status = rdq_pkg::STS_EMPTY;
              end else begin
                // fetch the head entry, results stream from ST_DUMP
                rd_en   = 1'b1;
                raddr   = head_q;
                off_d   = '0;
                state_d = rdq_pkg::ST_DUMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      rdq_pkg::ST_DUMP: begin
        // read data for off_q is ready; emit it and fetch the next entry
        if (out_free) begin
          load      = 1'b1;
          res.value = rd_data_q;
          res.last  = dump_last;
          if (dump_last) begin
            state_d = rdq_pkg::ST_IDLE;
          end else begin
            off_d = off_q + PtrW'(1);
            rd_en = 1'b1;
            raddr = ring_pos(head_q, off_d);
          end
        end
      end
      default: begin
        state_d = rdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdq_pkg::ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
      off_q   <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      off_q   <= off_d;
    end
  end

  // Entry store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_store_q[waddr] <= value_in_i;
    end
    if (rd_en) begin
      rd_data_q <= entry_store_q[raddr];
    end
  end

  rdq_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .res_i   (res),
    .stall_i (out_stall_i),
    .valid_o (out_valid_o),
    .free_o  (out_free),
    .res_o   (res_out)
  );

  assign value_out_o = res_out.value;
  assign status_o    = res_out.status;
  assign last_o      = res_out.last;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above depth");

  a_head_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= PtrW'(DEPTH - 1))
    else $error("head pointer out of range");

  a_empty_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> head_q == '0)
    else $error("empty ring with nonzero head");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rdq_pkg::ST_DUMP |-> count_q != '0 && CntW'(off_q) < count_q)
    else $error("dump offset past stored entries");

  a_dump_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rdq_pkg::ST_DUMP && !out_free |=> $stable(off_q) && $stable(rd_data_q))
    else $error("dump advanced while output was stalled");

endmodule
